/* sv/fpe_pkg.sv */
// Shared types, constants and helper functions of the frustum plane extractor.
`timescale 1ns / 1ps
package fpe_pkg;

  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned NumPlanes     = 6;

  localparam logic [1:0] GroupD = 2'd3;
  localparam logic [2:0] PlaneLast = 3'd5;

  typedef logic signed [32:0] comp_t;

  typedef struct packed {
    logic [2:0] plane_idx;
    logic       incomplete;
    logic       last;
    comp_t      v_x;
    comp_t      v_y;
    comp_t      v_z;
    comp_t      v_d;
  } job_t;

  // Planes formed as w + u: left, bottom and near.
  function automatic logic plane_add(input logic [2:0] p);
    logic r;
    case (p)
      3'd0:    r = 1'b1;
      3'd3:    r = 1'b1;
      3'd5:    r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [32:0] comp_mag(input comp_t v);
    logic [32:0] r;
    r = v[32] ? (33'd0 - $unsigned(v)) : $unsigned(v);
    return r;
  endfunction

endpackage

/* sv/fpe_if.sv */
// Valid/ready channel interfaces for matrix groups and plane results.
`timescale 1ns / 1ps
interface fpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  group;
  logic [31:0] elem0;
  logic [31:0] elem1;
  logic [31:0] elem2;
  logic [31:0] elem3;
  modport source (output valid, group, elem0, elem1, elem2, elem3, input ready);
  modport sink (input valid, group, elem0, elem1, elem2, elem3, output ready);
endinterface

interface fpe_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  plane_index;
  logic [31:0] normal_x;
  logic [31:0] normal_y;
  logic [31:0] normal_z;
  logic [31:0] plane_dist;
  logic        degenerate;
  logic        incomplete;
  logic        last;
  modport source (output valid, plane_index, normal_x, normal_y, normal_z, plane_dist,
                  degenerate, incomplete, last, input ready);
  modport sink (input valid, plane_index, normal_x, normal_y, normal_z, plane_dist,
                degenerate, incomplete, last, output ready);
endinterface

/* sv/frustum_plane_extract_core.sv */
// Top level of the frustum clip-plane extractor.
`timescale 1ns / 1ps
// Send the view-projection matrix as groups 0, 1 and 2 (one cycle each) and then
// group 3; group 3 releases six planes, left, right, top, bottom, far, near, with
// last set on the near plane. The front end takes groups while it is loading and, on
// group 3, hands the six plane jobs to a short queue, one per cycle while the queue
// has room, and takes no group until the last job is queued; the back end works
// through each plane with a one-bit-per-cycle multiplier, a one-bit-per-cycle
// square root and four one-bit-per-cycle rounding divisions. An incomplete run
// passes each plane without the arithmetic, and a degenerate plane skips the
// square root and the divisions. The next matrix's first groups are taken while
// the back end is still busy.
module frustum_plane_extract_core #(
  parameter int unsigned QueueDepth = fpe_pkg::QueueDepthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  fpe_in_if.sink   in_i,
  fpe_out_if.source out_o
);
  import fpe_pkg::*;

  localparam int unsigned JobW = $bits(job_t);

  job_t            front_job, back_job;
  logic            front_valid, front_ready;
  logic            back_valid, back_ready;
  logic [JobW-1:0] back_bits;

  fpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  fpe_fifo #(
    .Width (JobW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wdata_i  (front_job),
    .wvalid_i (front_valid),
    .wready_o (front_ready),
    .rdata_o  (back_bits),
    .rvalid_o (back_valid),
    .rready_i (back_ready)
  );

  assign back_job = job_t'(back_bits);

  fpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

/* sv/fpe_front.sv */
// Front end: stores matrix groups and issues one plane job per plane on group 3.
`timescale 1ns / 1ps
module fpe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  fpe_in_if.sink             in_i,
  output fpe_pkg::job_t      job_o,
  output logic               job_valid_o,
  input  logic               job_ready_i
);
  import fpe_pkg::*;

  typedef enum logic [1:0] {
    F_LOAD = 2'b01,
    F_EMIT = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;
  logic [2:0]  loaded_q, loaded_d;
  logic        inc_q, inc_d;
  logic [2:0]  pidx_q, pidx_d;
  logic [31:0] store_q [3][4];
  logic [31:0] e3_q [4];
  logic        acc_in;

  assign in_i.ready = (state_q == F_LOAD);
  assign acc_in     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i) begin
    if (acc_in && in_i.group != GroupD) begin
      store_q[in_i.group][0] <= in_i.elem0;
      store_q[in_i.group][1] <= in_i.elem1;
      store_q[in_i.group][2] <= in_i.elem2;
      store_q[in_i.group][3] <= in_i.elem3;
    end
    if (acc_in && in_i.group == GroupD) begin
      e3_q[0] <= in_i.elem0;
      e3_q[1] <= in_i.elem1;
      e3_q[2] <= in_i.elem2;
      e3_q[3] <= in_i.elem3;
    end
  end

  always_comb begin
    state_d  = state_q;
    loaded_d = loaded_q;
    inc_d    = inc_q;
    pidx_d   = pidx_q;
    case (state_q)
      F_LOAD: begin
        if (acc_in) begin
          if (in_i.group == GroupD) begin
            inc_d    = (loaded_q != 3'b111);
            loaded_d = 3'b000;
            pidx_d   = 3'd0;
            state_d  = F_EMIT;
          end else begin
            loaded_d = loaded_q | (3'b001 << in_i.group);
          end
        end
      end
      F_EMIT: begin
        if (job_ready_i) begin
          pidx_d = pidx_q + 3'd1;
          if (pidx_q == PlaneLast) begin
            state_d = F_LOAD;
          end
        end
      end
      default: state_d = F_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_LOAD;
      loaded_q <= 3'b000;
      inc_q    <= 1'b0;
      pidx_q   <= 3'd0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      inc_q    <= inc_d;
      pidx_q   <= pidx_d;
    end
  end

  // Column of the plane: x for left/right, y for top/bottom, z for far/near.
  logic [1:0] col;
  logic       add;
  comp_t      v [4];

  assign col = pidx_q[2:1];
  assign add = plane_add(pidx_q);

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      logic [31:0] w;
      logic [31:0] u;
      w = (a < 3) ? store_q[a[1:0]][3] : e3_q[3];
      u = (a < 3) ? store_q[a[1:0]][col] : e3_q[col];
      v[a] = add ? ($signed({w[31], w}) + $signed({u[31], u}))
                 : ($signed({w[31], w}) - $signed({u[31], u}));
    end
  end

  assign job_valid_o        = (state_q == F_EMIT);
  assign job_o.plane_idx    = pidx_q;
  assign job_o.incomplete   = inc_q;
  assign job_o.last         = (pidx_q == PlaneLast);
  assign job_o.v_x          = v[0];
  assign job_o.v_y          = v[1];
  assign job_o.v_z          = v[2];
  assign job_o.v_d          = v[3];

endmodule

/* sv/fpe_fifo.sv */
// Small register queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module fpe_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [Width-1:0] wdata_i,
  input  logic             wvalid_i,
  output logic             wready_o,
  output logic [Width-1:0] rdata_o,
  output logic             rvalid_o,
  input  logic             rready_i
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  assign wready_o = (cnt_q != CntW'(Depth));
  assign rvalid_o = (cnt_q != '0);
  assign push     = wvalid_i && wready_o;
  assign pop      = rvalid_o && rready_i;
  assign rdata_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

endmodule

/* sv/fpe_back.sv */
// Back end: serial squares, square root and rounding divisions for one plane.
`timescale 1ns / 1ps
module fpe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fpe_pkg::job_t  job_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  fpe_out_if.source      out_o
);
  import fpe_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_MUL  = 6'b000010,
    B_SQRT = 6'b000100,
    B_DIV  = 6'b001000,
    B_FIN  = 6'b010000,
    B_OUT  = 6'b100000
  } back_state_e;

  localparam logic [6:0] MulLast  = 7'd32;
  localparam logic [6:0] SqrtLast = 7'd48;
  localparam logic [6:0] DivLast  = 7'd80;
  localparam logic [1:0] CompD    = 2'd3;
  localparam logic [1:0] CompZ    = 2'd2;

  back_state_e state_q;
  job_t        job_q;
  logic [1:0]  comp_q;
  logic [6:0]  cnt_q;
  logic [65:0] mcand_q, acc_q;
  logic [32:0] mplier_q;
  logic [97:0] rad_q;
  logic [50:0] rem_q;
  logic [48:0] root_q;
  logic [80:0] num_q;
  logic [50:0] drem_q;
  logic [32:0] quot_q;
  logic        ovf_q;
  logic [31:0] res_q [4];
  logic        deg_q;

  comp_t       cur_v;
  logic [32:0] cur_m;

  always_comb begin
    case (comp_q)
      2'd0:    cur_v = job_q.v_x;
      2'd1:    cur_v = job_q.v_y;
      2'd2:    cur_v = job_q.v_z;
      default: cur_v = job_q.v_d;
    endcase
  end
  assign cur_m = comp_mag(cur_v);

  // Square root step: one root bit per cycle.
  logic [52:0] sq_rem, sq_trial;
  logic        sq_ge;
  assign sq_rem   = {rem_q, rad_q[97:96]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = (sq_rem >= sq_trial);

  // Division step: one quotient bit per cycle against twice the root.
  logic [51:0] dv_rem, dv_den;
  logic        dv_ge;
  assign dv_rem = {drem_q, num_q[80]};
  assign dv_den = {1'b0, root_q, 2'b00} >> 1;
  assign dv_ge  = (dv_rem >= dv_den);

  // Rounded numerator: magnitude shifted by k + 1, plus the root.
  logic [80:0] num_init;
  assign num_init = ((comp_q == CompD) ? ({48'd0, cur_m} << 33) : ({48'd0, cur_m} << 47))
                    + {32'd0, root_q};

  logic        fin_neg;
  logic [32:0] fin_cap, fin_q;
  logic [31:0] fin_val;
  assign fin_neg = !cur_v[32] && (cur_v != '0);
  assign fin_cap = (comp_q != CompD) ? 33'h040000000 :
                   (fin_neg ? 33'h080000000 : 33'h07FFFFFFF);
  assign fin_q   = (ovf_q || quot_q > fin_cap) ? fin_cap : quot_q;
  assign fin_val = fin_neg ? 32'(33'd0 - fin_q) : fin_q[31:0];

  assign job_ready_o = (state_q == B_IDLE);

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_q  <= job_i;
          deg_q  <= 1'b0;
          acc_q  <= '0;
          for (int a = 0; a < 4; a++) res_q[a] <= '0;
          mcand_q  <= {33'd0, comp_mag(job_i.v_x)};
          mplier_q <= comp_mag(job_i.v_x);
        end
      end
      B_MUL: begin
        if (mplier_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        if (cnt_q == MulLast) begin
          mcand_q  <= {33'd0, comp_mag((comp_q == 2'd0) ? job_q.v_y : job_q.v_z)};
          mplier_q <= comp_mag((comp_q == 2'd0) ? job_q.v_y : job_q.v_z);
          if (comp_q == CompZ) begin
            rad_q  <= {(mplier_q[0] ? acc_q + mcand_q : acc_q), 32'd0};
            rem_q  <= '0;
            root_q <= '0;
            deg_q  <= ((mplier_q[0] ? acc_q + mcand_q : acc_q) == '0);
          end
        end else begin
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
        end
      end
      B_SQRT: begin
        rad_q <= rad_q << 2;
        if (sq_ge) begin
          rem_q  <= 51'(sq_rem - sq_trial);
          root_q <= {root_q[47:0], 1'b1};
        end else begin
          rem_q  <= sq_rem[50:0];
          root_q <= {root_q[47:0], 1'b0};
        end
      end
      B_DIV: begin
        if (cnt_q == '0) begin
          num_q  <= num_init << 1;
          drem_q <= {50'd0, num_init[80]} >= {1'b0, root_q, 1'b0} ?
                    51'({51'd0, num_init[80]} - {2'b0, root_q, 1'b0}) : {50'd0, num_init[80]};
          quot_q <= {32'd0, ({50'd0, num_init[80]} >= {1'b0, root_q, 1'b0})};
          ovf_q  <= 1'b0;
        end else begin
          num_q  <= num_q << 1;
          drem_q <= dv_ge ? 51'(dv_rem - dv_den) : dv_rem[50:0];
          quot_q <= {quot_q[31:0], dv_ge};
          ovf_q  <= ovf_q | quot_q[32];
        end
      end
      B_FIN: begin
        res_q[comp_q] <= fin_val;
      end
      default: ;
    endcase
    // Clear the divider state for the next component.
    if ((state_q == B_SQRT && cnt_q == SqrtLast) || (state_q == B_FIN && comp_q != CompD)) begin
      drem_q <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      comp_q  <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (job_valid_i) begin
            comp_q  <= '0;
            cnt_q   <= '0;
            state_q <= job_i.incomplete ? B_OUT : B_MUL;
          end
        end
        B_MUL: begin
          if (cnt_q == MulLast) begin
            cnt_q <= '0;
            if (comp_q == CompZ) begin
              comp_q  <= '0;
              state_q <= ((mplier_q[0] ? acc_q + mcand_q : acc_q) == '0) ? B_OUT : B_SQRT;
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        B_SQRT: begin
          if (cnt_q == SqrtLast) begin
            cnt_q   <= '0;
            state_q <= B_DIV;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        B_DIV: begin
          if (cnt_q == DivLast) begin
            cnt_q   <= '0;
            state_q <= B_FIN;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        B_FIN: begin
          if (comp_q == CompD) begin
            state_q <= B_OUT;
          end else begin
            comp_q  <= comp_q + 2'd1;
            state_q <= B_DIV;
          end
        end
        B_OUT: begin
          if (out_o.ready) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  assign out_o.valid       = (state_q == B_OUT);
  assign out_o.plane_index = job_q.plane_idx;
  assign out_o.normal_x    = res_q[0];
  assign out_o.normal_y    = res_q[1];
  assign out_o.normal_z    = res_q[2];
  assign out_o.plane_dist  = res_q[3];
  assign out_o.degenerate  = deg_q && !job_q.incomplete;
  assign out_o.incomplete  = job_q.incomplete;
  assign out_o.last        = job_q.last;

endmodule

/* sv/fpe_checker.sv */
// Port-level assertions for the frustum plane extractor, bound to the top level.
`timescale 1ns / 1ps
module fpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  plane_index_i,
  input logic [31:0] normal_x_i,
  input logic [31:0] normal_y_i,
  input logic [31:0] normal_z_i,
  input logic [31:0] plane_dist_i,
  input logic        degenerate_i,
  input logic        incomplete_i,
  input logic        last_i
);

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (plane_index_i <= 3'd5))
    else $error("plane index out of range");

  a_last_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_i == (plane_index_i == 3'd5)))
    else $error("last flag not on the near plane");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(degenerate_i && incomplete_i))
    else $error("degenerate and incomplete both set");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (degenerate_i || incomplete_i)) |->
      (normal_x_i == '0 && normal_y_i == '0 && normal_z_i == '0 && plane_dist_i == '0))
    else $error("flagged plane carries nonzero values");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(plane_index_i)
      && $stable(normal_x_i) && $stable(plane_dist_i)))
    else $error("stalled result changed");

endmodule

bind frustum_plane_extract_core fpe_checker u_fpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .plane_index_i (out_o.plane_index),
  .normal_x_i    (out_o.normal_x),
  .normal_y_i    (out_o.normal_y),
  .normal_z_i    (out_o.normal_z),
  .plane_dist_i  (out_o.plane_dist),
  .degenerate_i  (out_o.degenerate),
  .incomplete_i  (out_o.incomplete),
  .last_i        (out_o.last)
);

/* verif/fpe_checker.sv */
// Checker for the frustum plane extractor: predicts the six planes per matrix and compares.
`timescale 1ns / 1ps
module fpe_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  fpe_in_if    in_mon,
  fpe_out_if   out_mon,
  output int   mismatches_o,
  output int   pending_o
);
  import fpe_pkg::*;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic [31:0] pdist;
    logic        degenerate;
    logic        incomplete;
    logic        last;
  } plane_t;

  plane_t      plane_q[$];
  logic [31:0] mat[12];
  logic [2:0]  have_groups;
  int          mismatches;

  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [63:0]  res;
    logic [63:0]  t;
    logic [127:0] sq;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      t  = res | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (sq <= v) res = t;
    end
    return res;
  endfunction

  // Rounds |v| * 2^k / len to nearest, halves away from zero, then applies the
  // sign of -v and the clamp for normals or distance.
  function automatic logic [31:0] scale_comp(input logic signed [33:0] v, input int k,
                                             input logic [63:0] len, input bit is_normal);
    logic [127:0] mag, num, q, cap;
    logic [33:0]  neg_v;
    bit           neg;
    neg_v = -v;
    mag   = v[33] ? {94'd0, neg_v} : {94'd0, v};
    neg   = !v[33] && (v != 0);
    if (is_normal) cap = 128'd1 << 30;
    else cap = neg ? (128'd1 << 31) : 128'h7FFF_FFFF;
    num = (mag << (k + 1)) + {64'd0, len};
    q   = num / ({64'd0, len} << 1);
    if (q > cap) q = cap;
    return neg ? 32'(-q) : q[31:0];
  endfunction

  task automatic predict_planes(input logic [31:0] e3[4], input bit incomplete);
    plane_t             pl;
    logic signed [33:0] comp[4];
    logic signed [33:0] w, u;
    logic [33:0]        m;
    logic [127:0]       sum;
    logic [63:0]        len;
    int                 col;
    for (int p = 0; p < NumPlanes; p++) begin
      pl            = '0;
      pl.idx        = 3'(p);
      pl.last       = (3'(p) == PlaneLast);
      pl.incomplete = incomplete;
      if (!incomplete) begin
        col = p / 2;
        sum = '0;
        for (int a = 0; a < 4; a++) begin
          w = (a < 3) ? $signed(mat[a * 4 + 3]) : $signed(e3[3]);
          u = (a < 3) ? $signed(mat[a * 4 + col]) : $signed(e3[col]);
          comp[a] = plane_add(3'(p)) ? w + u : w - u;
          if (a < 3) begin
            m   = comp[a][33] ? 34'(-comp[a]) : comp[a];
            sum = sum + {94'd0, m} * {94'd0, m};
          end
        end
        if (sum == 0) begin
          pl.degenerate = 1'b1;
        end else begin
          len      = isqrt(sum << 32);
          pl.nx    = scale_comp(comp[0], 46, len, 1'b1);
          pl.ny    = scale_comp(comp[1], 46, len, 1'b1);
          pl.nz    = scale_comp(comp[2], 46, len, 1'b1);
          pl.pdist = scale_comp(comp[3], 32, len, 1'b0);
        end
      end
      plane_q.push_back(pl);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    plane_t      got, want;
    logic [31:0] e3[4];
    if (!rst_ni) begin
      have_groups = '0;
      mismatches  = 0;
      plane_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        e3[0] = in_mon.elem0;
        e3[1] = in_mon.elem1;
        e3[2] = in_mon.elem2;
        e3[3] = in_mon.elem3;
        if (in_mon.group == GroupD) begin
          predict_planes(e3, have_groups != 3'b111);
          have_groups = '0;
        end else begin
          for (int a = 0; a < 4; a++) mat[in_mon.group * 4 + a] = e3[a];
          have_groups[in_mon.group] = 1'b1;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.plane_index, out_mon.normal_x, out_mon.normal_y, out_mon.normal_z,
                out_mon.plane_dist, out_mon.degenerate, out_mon.incomplete, out_mon.last};
        if (plane_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected plane transfer %p", got);
        end else begin
          want = plane_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: plane mismatch\n  expected %p\n  actual   %p", want, got);
          end
        end
      end
    end
    mismatches_o = mismatches;
    pending_o    = plane_q.size();
  end

endmodule

/* verif/tb.sv */
// Top of the frustum plane extractor testbench: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb;
  import fpe_pkg::*;

  localparam int unsigned NumItems   = 430;
  localparam int unsigned CycleLimit = 4_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   in_xfers = 0;
  int   out_xfers = 0;
  int   cycles = 0;
  int   sent = 0;
  int   mismatches, pending;
  bit   burst = 1'b0;

  fpe_in_if  in_if ();
  fpe_out_if out_if ();

  frustum_plane_extract_core dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if), .out_o(out_if));

  fpe_scoreboard u_scoreboard (.clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_if), .out_mon(out_if),
                               .mismatches_o(mismatches), .pending_o(pending));

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_if.valid && in_if.ready) in_xfers <= in_xfers + 1;
    if (out_if.valid && out_if.ready) out_xfers <= out_xfers + 1;
    if (cycles > CycleLimit) begin
      $display("frustum_plane_extract_core verification failed");
      $finish;
    end
  end

  task automatic send_group(input logic [1:0] g, input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic [31:0] d);
    int gap, n0;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.group <= g;
    in_if.elem0 <= a;
    in_if.elem1 <= b;
    in_if.elem2 <= c;
    in_if.elem3 <= d;
    n0 = in_xfers;
    do @(negedge clk_i); while (in_xfers == n0);
    sent++;
  endtask

  function automatic logic [31:0] rand_elem();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 1 << 18) - (1 << 17);
      2: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: v = '0;
      default: v = $urandom_range(0, 1 << 22) - (1 << 21);
    endcase
    return v;
  endfunction

  task automatic send_rand(input logic [1:0] g);
    send_group(g, rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endtask

  // Output side: each plane waits a drawn number of cycles before ready rises.
  initial begin
    int n, n0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = burst ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      n0 = out_xfers;
      do @(negedge clk_i); while (out_xfers == n0);
    end
  end

  initial begin
    int          order[3];
    int          tmp, j;
    logic [31:0] one;
    one          = 32'h0001_0000;
    in_if.valid  = 1'b0;
    in_if.group  = '0;
    in_if.elem0  = '0;
    in_if.elem1  = '0;
    in_if.elem2  = '0;
    in_if.elem3  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Identity matrix.
    send_group(2'd0, one, 0, 0, 0);
    send_group(2'd1, 0, one, 0, 0);
    send_group(2'd2, 0, 0, one, 0);
    send_group(GroupD, 0, 0, 0, one);
    // All elements at the negative and positive extremes.
    for (int g = 0; g < 4; g++) send_group(2'(g), 32'h8000_0000, 32'h8000_0000,
                                           32'h8000_0000, 32'h8000_0000);
    for (int g = 0; g < 4; g++) send_group(2'(g), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                           32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // Zero normals give degenerate planes.
    for (int g = 0; g < 3; g++) send_group(2'(g), 0, 0, 0, 0);
    send_group(GroupD, 32'h1234_5678, 0, 32'hFFFF_0000, 32'h7FFF_0000);
    // Tiny normals with a huge distance saturate the distance.
    send_group(2'd0, 0, 0, 0, 1);
    send_group(2'd1, 0, 0, 0, 0);
    send_group(2'd2, 0, 0, 0, 0);
    send_group(GroupD, 0, 0, 0, 32'h7FFF_FFFF);
    // Missing groups, then a reloaded group.
    send_group(GroupD, one, one, one, one);
    send_group(2'd0, one, 0, 0, 0);
    send_group(2'd2, 0, 0, one, 0);
    send_group(GroupD, 0, 0, 0, one);
    send_group(2'd1, 32'hDEAD_BEEF, 1, 2, 3);
    send_group(2'd0, one, 0, 0, 0);
    send_group(2'd1, 0, one, 0, 0);
    send_group(2'd2, 0, 0, one, 0);
    send_group(GroupD, 0, 0, 0, one);

    while (sent < NumItems) begin
      if ($urandom_range(0, 7) == 0) burst = ~burst;
      if ($urandom_range(0, 99) < 85) begin
        order = '{0, 1, 2};
        for (int i = 2; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < 3; i++) send_rand(2'(order[i]));
        if ($urandom_range(0, 9) == 0) send_rand(2'($urandom_range(0, 2)));
      end else begin
        repeat ($urandom_range(0, 3)) send_rand(2'($urandom_range(0, 2)));
      end
      send_rand(GroupD);
    end
    in_if.valid <= 1'b0;
    burst = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("frustum_plane_extract_core verification clean");
    end else begin
      $display("frustum_plane_extract_core verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/fpe_pkg.sv
sv/fpe_if.sv
sv/fpe_front.sv
sv/fpe_fifo.sv
sv/fpe_back.sv
sv/frustum_plane_extract_core.sv
sv/fpe_checker.sv
verif/fpe_checker.sv
verif/tb.sv
